FILE: hw/rtl/slseg_pkg.sv
// Shared types, constants and classification functions of the script language segmenter.
package slseg_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int SEG_BITS        = 16;
    localparam int CP_BITS         = 21;
    localparam int CFG_IDX_BITS    = 4;
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [2:0] {
        LANG_JA    = 3'd0,
        LANG_ZH    = 3'd1,
        LANG_KO    = 3'd2,
        LANG_LATIN = 3'd3,
        LANG_NONE  = 3'd4
    } t_lang;

    localparam logic [CFG_IDX_BITS-1:0] CFG_JA    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_ZH    = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_KO    = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_LATIN = CFG_IDX_BITS'(3);

    typedef struct packed {
        logic ja;
        logic zh;
        logic ko;
        logic latin;
    } t_cfg;

    typedef struct packed {
        logic [1:0]          lang;
        logic [SEG_BITS-1:0] offset;
        logic [SEG_BITS-1:0] length;
        logic                saturated;
        logic                last_segment;
    } t_seg;

    // One queue entry holds the results of one item, first always valid.
    typedef struct packed {
        logic two;
        t_seg first;
        t_seg second;
    } t_rec;

    function automatic logic in_range(input logic [CP_BITS-1:0] c,
                                      input logic [CP_BITS-1:0] lo,
                                      input logic [CP_BITS-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic t_lang classify(input logic [CP_BITS-1:0] c,
                                       input logic kana_ctx,
                                       input t_cfg cfg);
        logic is_kana;
        logic is_hangul;
        logic is_han;
        logic is_latin;
        t_lang res;
        is_kana   = in_range(c, 21'h3040, 21'h309F) || in_range(c, 21'h30A0, 21'h30FF) ||
                    in_range(c, 21'h31F0, 21'h31FF) || in_range(c, 21'hFF65, 21'hFF9F);
        is_hangul = in_range(c, 21'hAC00, 21'hD7AF) || in_range(c, 21'h1100, 21'h11FF) ||
                    in_range(c, 21'h3130, 21'h318F) || in_range(c, 21'hFFA0, 21'hFFDC);
        is_han    = in_range(c, 21'h4E00, 21'h9FFF) || in_range(c, 21'h3400, 21'h4DBF) ||
                    in_range(c, 21'hF900, 21'hFAFF);
        is_latin  = in_range(c, 21'hFF21, 21'hFF3A) || in_range(c, 21'hFF41, 21'hFF5A) ||
                    in_range(c, 21'h0041, 21'h005A) || in_range(c, 21'h0061, 21'h007A) ||
                    in_range(c, 21'h00C0, 21'h00D6) || in_range(c, 21'h00D8, 21'h00F6) ||
                    in_range(c, 21'h00F8, 21'h00FF);
        res = LANG_NONE;
        if (is_kana) begin
            res = cfg.ja ? LANG_JA : LANG_NONE;
        end else if (is_hangul) begin
            res = cfg.ko ? LANG_KO : LANG_NONE;
        end else if (is_han) begin
            if (cfg.ja && cfg.zh) begin
                res = kana_ctx ? LANG_JA : LANG_ZH;
            end else if (cfg.ja) begin
                res = LANG_JA;
            end else if (cfg.zh) begin
                res = LANG_ZH;
            end
        end else if (is_latin) begin
            res = cfg.latin ? LANG_LATIN : LANG_NONE;
        end
        return res;
    endfunction

    function automatic logic [2:0] utf8_size(input logic [CP_BITS-1:0] c);
        logic [2:0] sz;
        if (c < 21'h80) begin
            sz = 3'd1;
        end else if (c < 21'h800) begin
            sz = 3'd2;
        end else if (c < 21'h10000) begin
            sz = 3'd3;
        end else begin
            sz = 3'd4;
        end
        return sz;
    endfunction

endpackage

FILE: hw/rtl/slseg_front.sv
// Front part: configuration registers, classification and per-text segment state.
module slseg_front
    import slseg_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic                    i_cfg_data,
    input  logic                    i_valid,
    input  logic [CP_BITS-1:0]      i_codepoint,
    input  logic                    i_context_has_kana,
    input  logic                    i_last,
    input  logic                    i_accept,
    output logic                    o_push,
    output t_rec                    o_rec
);

    localparam logic [OFFSET_BITS-1:0] MAX_POS = '1;

    t_cfg                   r_cfg;
    t_lang                  r_cur;
    logic [OFFSET_BITS-1:0] r_start;
    logic [OFFSET_BITS-1:0] r_pos;
    logic                   r_seen;
    logic                   r_emitted;
    logic                   r_ovf;

    t_lang                  cls;
    logic                   ws;
    logic                   seen_new;
    logic                   change;
    t_lang                  cur_mid;
    logic [OFFSET_BITS-1:0] start_mid;
    logic                   emitted_mid;
    logic [OFFSET_BITS:0]   sum;
    logic [OFFSET_BITS-1:0] pos_new;
    logic                   ovf_new;
    logic                   fin_lang;
    logic                   fin_default;
    t_seg                   seg_change;
    t_seg                   seg_final;

    function automatic logic [SEG_BITS-1:0] to_seg(input logic [OFFSET_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[SEG_BITS-1:0];
    endfunction

    always_comb begin
        cls         = classify(i_codepoint, i_context_has_kana, r_cfg);
        ws          = (i_codepoint == 21'h20) || (i_codepoint == 21'h09) ||
                      (i_codepoint == 21'h0A) || (i_codepoint == 21'h0D);
        seen_new    = r_seen | ~ws;
        change      = (cls != LANG_NONE) && (r_cur != LANG_NONE) && (cls != r_cur);
        cur_mid     = (cls != LANG_NONE) ? cls : r_cur;
        start_mid   = change ? r_pos : r_start;
        emitted_mid = r_emitted | change;
        sum         = {1'b0, r_pos} + (OFFSET_BITS + 1)'(utf8_size(i_codepoint));
        pos_new     = sum[OFFSET_BITS] ? MAX_POS : sum[OFFSET_BITS-1:0];
        ovf_new     = r_ovf | sum[OFFSET_BITS];
        fin_lang    = i_last && (cur_mid != LANG_NONE);
        fin_default = i_last && (cur_mid == LANG_NONE) && !emitted_mid && seen_new;

        seg_change.lang         = r_cur[1:0];
        seg_change.offset       = to_seg(r_start);
        seg_change.length       = to_seg(r_pos - r_start);
        seg_change.saturated    = r_ovf;
        seg_change.last_segment = 1'b0;

        if (fin_lang) begin
            seg_final.lang   = cur_mid[1:0];
            seg_final.offset = to_seg(start_mid);
            seg_final.length = to_seg(pos_new - start_mid);
        end else begin
            seg_final.lang   = 2'(LANG_LATIN);
            seg_final.offset = '0;
            seg_final.length = to_seg(pos_new);
        end
        seg_final.saturated    = ovf_new;
        seg_final.last_segment = 1'b1;

        o_rec.two    = change && (fin_lang || fin_default);
        o_rec.first  = change ? seg_change : seg_final;
        o_rec.second = seg_final;
        o_push       = i_accept && (change || fin_lang || fin_default);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= '0;
            r_cur     <= LANG_NONE;
            r_start   <= '0;
            r_pos     <= '0;
            r_seen    <= 1'b0;
            r_emitted <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_JA:    r_cfg.ja    <= i_cfg_data;
                    CFG_ZH:    r_cfg.zh    <= i_cfg_data;
                    CFG_KO:    r_cfg.ko    <= i_cfg_data;
                    CFG_LATIN: r_cfg.latin <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                if (i_last) begin
                    r_cur     <= LANG_NONE;
                    r_start   <= '0;
                    r_pos     <= '0;
                    r_seen    <= 1'b0;
                    r_emitted <= 1'b0;
                    r_ovf     <= 1'b0;
                end else begin
                    r_cur     <= cur_mid;
                    r_start   <= start_mid;
                    r_pos     <= pos_new;
                    r_seen    <= seen_new;
                    r_emitted <= emitted_mid;
                    r_ovf     <= ovf_new;
                end
            end
        end
    end

    // A result record is only queued while a valid input item is present.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_valid)
        else $error("Result record queued without a valid item.");

    // The start of the open segment never passes the byte position.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start <= r_pos)
        else $error("Segment start beyond byte position.");

    // After the final item of a text all per-text state is back at rest.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_pos == '0) && (r_cur == LANG_NONE) && !r_ovf)
        else $error("Text state not cleared after final item.");

endmodule

FILE: hw/rtl/slseg_fifo.sv
// Short queue of result records between the front and back parts.
module slseg_fifo
    import slseg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_rec o_rec
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    t_rec                r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [CNT_BITS-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("Push into a full queue.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("Pop from an empty queue.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("Queue count did not follow a push.");

endmodule

FILE: hw/rtl/slseg_back.sv
// Back part: takes result records from the queue and presents them one result at a time.
module slseg_back
    import slseg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rec_valid,
    input  t_rec                i_rec,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_lang,
    output logic [SEG_BITS-1:0] o_seg_offset,
    output logic [SEG_BITS-1:0] o_seg_length,
    output logic                o_saturated,
    output logic                o_last_segment
);

    t_rec r_rec;
    logic r_have;
    logic r_second;
    t_seg seg;
    logic out_acc;
    logic rec_done;

    always_comb begin
        out_acc  = r_have && i_ready;
        rec_done = out_acc && (r_second || !r_rec.two);
        o_pop    = i_rec_valid && (!r_have || rec_done);
        seg      = r_second ? r_rec.second : r_rec.first;
    end

    assign o_valid        = r_have;
    assign o_lang         = seg.lang;
    assign o_seg_offset   = seg.offset;
    assign o_seg_length   = seg.length;
    assign o_saturated    = seg.saturated;
    assign o_last_segment = seg.last_segment;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have   <= 1'b1;
                r_second <= 1'b0;
            end else if (rec_done) begin
                r_have   <= 1'b0;
                r_second <= 1'b0;
            end else if (out_acc) begin
                r_second <= 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_have && r_rec.two))
        else $error("Second result selected without a two-result record.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_have && r_rec.two && !r_second) |-> !o_last_segment)
        else $error("Final flag on the leading result of a record.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_rec.two && !r_second) |=> (r_have && r_second))
        else $error("Second result of a record was dropped.");

endmodule

FILE: hw/rtl/script_language_segmenter.sv
// Top level of the script language segmenter.
// One decoded codepoint is accepted per cycle while the result queue has room; the front
// classifies it and updates the segment state in that same cycle, so the sustained input
// rate is one item per clock. An item yields zero, one or two segment results; these pass
// through a four-entry queue to an output register that delivers one result per cycle while
// the receiver is ready, so texts with many language changes are limited by the output side
// at one result per clock. Results pass the queue memory and then the output register.
// Byte counters are OFFSET_BITS wide and saturate; offsets and lengths are reported in
// their low 16 bits. Configuration writes are always accepted and should be made only
// while no text is in progress and the outputs are drained.
module script_language_segmenter
    import slseg_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic                    i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [CP_BITS-1:0]      i_codepoint,
    input  logic                    i_context_has_kana,
    input  logic                    i_last,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [1:0]              o_lang,
    output logic [SEG_BITS-1:0]     o_seg_offset,
    output logic [SEG_BITS-1:0]     o_seg_length,
    output logic                    o_saturated,
    output logic                    o_last_segment
);

    logic in_acc;
    logic push;
    t_rec push_rec;
    logic full;
    logic pop;
    logic q_valid;
    t_rec q_rec;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !full;
    assign in_acc      = i_valid && !full;

    slseg_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .i_codepoint       (i_codepoint),
        .i_context_has_kana(i_context_has_kana),
        .i_last            (i_last),
        .i_accept          (in_acc),
        .o_push            (push),
        .o_rec             (push_rec)
    );

    slseg_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_rec  (push_rec),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_rec  (q_rec)
    );

    slseg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec_valid   (q_valid),
        .i_rec         (q_rec),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_lang        (o_lang),
        .o_seg_offset  (o_seg_offset),
        .o_seg_length  (o_seg_length),
        .o_saturated   (o_saturated),
        .o_last_segment(o_last_segment)
    );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench of the script language segmenter with a built-in segment predictor.
`timescale 1ns / 1ps

module tb_top;
    import slseg_pkg::*;

    typedef struct packed {
        logic [CP_BITS-1:0] cp;
        logic               kana;
        logic               fin;
    } t_cp_item;

    localparam longint unsigned POS_MAX = (64'd1 << OFFSET_BITS_DEF) - 1;
    localparam int SETTLE_CYCLES = 12;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic                    i_cfg_data = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic [CP_BITS-1:0]      i_codepoint = '0;
    logic                    i_context_has_kana = 1'b0;
    logic                    i_last = 1'b0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [1:0]              o_lang;
    logic [SEG_BITS-1:0]     o_seg_offset;
    logic [SEG_BITS-1:0]     o_seg_length;
    logic                    o_saturated;
    logic                    o_last_segment;

    t_cp_item cp_pending[$];
    t_seg     segs_due[$];
    logic     in_taken = 1'b0;
    int       send_idle = 0;
    int       recv_idle = 0;
    int       errs = 0;

    logic            en_ja, en_zh, en_ko, en_latin;
    t_lang           cur_lang;
    longint unsigned seg_start;
    longint unsigned byte_pos;
    logic            nonblank;
    logic            seg_done;
    logic            sat_seen;

    // Script ranges as lo/hi pairs: kana, Hangul, Han, Latin; then UTF-8 size edges.
    int unsigned cp_edges [44] = '{
        'h3040, 'h309F, 'h30A0, 'h30FF, 'h31F0, 'h31FF, 'hFF65, 'hFF9F,
        'hAC00, 'hD7AF, 'h1100, 'h11FF, 'h3130, 'h318F, 'hFFA0, 'hFFDC,
        'h4E00, 'h9FFF, 'h3400, 'h4DBF, 'hF900, 'hFAFF,
        'hFF21, 'hFF3A, 'hFF41, 'hFF5A, 'h0041, 'h005A, 'h0061, 'h007A,
        'h00C0, 'h00D6, 'h00D8, 'h00F6, 'h00F8, 'h00FF,
        'h007F, 'h0080, 'h07FF, 'h0800, 'hFFFF, 'h10000, 'h10FFFF, 'h1FFFFF
    };

    logic [3:0] lang_sets [9] = '{4'b1111, 4'b0000, 4'b1100, 4'b1000, 4'b0100,
                                  4'b0010, 4'b0001, 4'b1010, 4'b1111};

    script_language_segmenter dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_codepoint        (i_codepoint),
        .i_context_has_kana (i_context_has_kana),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_lang             (o_lang),
        .o_seg_offset       (o_seg_offset),
        .o_seg_length       (o_seg_length),
        .o_saturated        (o_saturated),
        .o_last_segment     (o_last_segment)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_lang script_of(input logic [CP_BITS-1:0] c, input logic kctx);
        t_lang r;
        r = LANG_NONE;
        if ((c >= 'h3040 && c <= 'h30FF) || (c >= 'h31F0 && c <= 'h31FF) ||
            (c >= 'hFF65 && c <= 'hFF9F)) begin
            r = en_ja ? LANG_JA : LANG_NONE;
        end else if ((c >= 'hAC00 && c <= 'hD7AF) || (c >= 'h1100 && c <= 'h11FF) ||
                     (c >= 'h3130 && c <= 'h318F) || (c >= 'hFFA0 && c <= 'hFFDC)) begin
            r = en_ko ? LANG_KO : LANG_NONE;
        end else if ((c >= 'h4E00 && c <= 'h9FFF) || (c >= 'h3400 && c <= 'h4DBF) ||
                     (c >= 'hF900 && c <= 'hFAFF)) begin
            if (en_ja && (!en_zh || kctx)) begin
                r = LANG_JA;
            end else if (en_zh) begin
                r = LANG_ZH;
            end
        end else if ((c >= 'hFF21 && c <= 'hFF3A) || (c >= 'hFF41 && c <= 'hFF5A) ||
                     (c >= 'h41 && c <= 'h5A) || (c >= 'h61 && c <= 'h7A) ||
                     (c >= 'hC0 && c <= 'hFF && c != 'hD7 && c != 'hF7)) begin
            r = en_latin ? LANG_LATIN : LANG_NONE;
        end
        return r;
    endfunction

    function automatic void add_segment(input t_lang lg, input longint unsigned off,
                                        input longint unsigned len, input logic fin);
        t_seg s;
        s.lang         = lg[1:0];
        s.offset       = off[SEG_BITS-1:0];
        s.length       = len[SEG_BITS-1:0];
        s.saturated    = sat_seen;
        s.last_segment = fin;
        segs_due.insert(segs_due.size(), s);
    endfunction

    function automatic void clear_text_state();
        cur_lang  = LANG_NONE;
        seg_start = 0;
        byte_pos  = 0;
        nonblank  = 1'b0;
        seg_done  = 1'b0;
        sat_seen  = 1'b0;
    endfunction

    function automatic void predict_segments(input logic [CP_BITS-1:0] c, input logic kctx,
                                             input logic fin);
        t_lang           lg;
        longint unsigned nbytes;
        lg = script_of(c, kctx);
        nbytes = (c < 'h80) ? 1 : (c < 'h800) ? 2 : (c < 'h10000) ? 3 : 4;
        if (c != 'h20 && c != 'h09 && c != 'h0A && c != 'h0D) begin
            nonblank = 1'b1;
        end
        if (lg != LANG_NONE && cur_lang != LANG_NONE && lg != cur_lang) begin
            add_segment(cur_lang, seg_start, byte_pos - seg_start, 1'b0);
            seg_done  = 1'b1;
            seg_start = byte_pos;
        end
        if (lg != LANG_NONE) begin
            cur_lang = lg;
        end
        if (byte_pos + nbytes > POS_MAX) begin
            byte_pos = POS_MAX;
            sat_seen = 1'b1;
        end else begin
            byte_pos = byte_pos + nbytes;
        end
        if (fin) begin
            if (cur_lang != LANG_NONE) begin
                add_segment(cur_lang, seg_start, byte_pos - seg_start, 1'b1);
            end else if (!seg_done && nonblank) begin
                add_segment(LANG_LATIN, 0, byte_pos, 1'b1);
            end
            clear_text_state();
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            predict_segments(i_codepoint, i_context_has_kana, i_last);
            in_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin : feed_codepoints
        t_cp_item nxt;
        if (i_rst_n && (in_taken || !i_valid)) begin
            in_taken = 1'b0;
            if (cp_pending.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                nxt = cp_pending.pop_front();
                i_valid            <= 1'b1;
                i_codepoint        <= nxt.cp;
                i_context_has_kana <= nxt.kana;
                i_last             <= nxt.fin;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin : check_segments
        t_seg got;
        t_seg want;
        if (i_rst_n && o_valid && i_ready) begin
            got.lang         = o_lang;
            got.offset       = o_seg_offset;
            got.length       = o_seg_length;
            got.saturated    = o_saturated;
            got.last_segment = o_last_segment;
            if (segs_due.size() == 0) begin
                errs++;
                if (errs <= 10) begin
                    $display("%0t: unexpected segment lang=%0d off=%0d len=%0d sat=%0b end=%0b",
                             $realtime, got.lang, got.offset, got.length, got.saturated,
                             got.last_segment);
                end
            end else begin
                want = segs_due.pop_front();
                if (got !== want) begin
                    errs++;
                    if (errs <= 10) begin
                        $display("%0t: segment mismatch lang %0d/%0d off %0d/%0d len %0d/%0d",
                                 $realtime, got.lang, want.lang, got.offset, want.offset,
                                 got.length, want.length);
                        $display("    sat %0b/%0b end %0b/%0b (got/expected)",
                                 got.saturated, want.saturated, got.last_segment,
                                 want.last_segment);
                    end
                end
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_JA:    en_ja = val;
            CFG_ZH:    en_zh = val;
            CFG_KO:    en_ko = val;
            CFG_LATIN: en_latin = val;
            default:   ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Bits of the setting are {ja, zh, ko, latin}.
    task automatic program_langs(input logic [3:0] s);
        cfg_write(CFG_LATIN, s[0]);
        cfg_write(CFG_KO, s[1]);
        cfg_write(CFG_ZH, s[2]);
        cfg_write(CFG_JA, s[3]);
        cfg_write(CFG_IDX_BITS'($urandom_range(int'(CFG_LATIN) + 1, 15)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        while (cp_pending.size() != 0 || i_valid) @(posedge i_clk);
        while (segs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void add_cp(input int unsigned c, input logic k, input logic fin);
        t_cp_item it;
        it.cp   = CP_BITS'(c);
        it.kana = k;
        it.fin  = fin;
        cp_pending.insert(cp_pending.size(), it);
    endfunction

    function automatic logic [CP_BITS-1:0] script_cp(input int first, input int n);
        int k;
        k = $urandom_range(first, first + n - 1);
        return CP_BITS'($urandom_range(cp_edges[2*k], cp_edges[2*k+1]));
    endfunction

    function automatic logic [CP_BITS-1:0] pick_cp(input int cat);
        logic [CP_BITS-1:0] c;
        case (cat)
            0: c = script_cp(0, 4);
            1: c = script_cp(4, 4);
            2: c = script_cp(8, 3);
            3: c = script_cp(11, 7);
            4: begin
                case ($urandom_range(0, 3))
                    0: c = 'h20;
                    1: c = 'h09;
                    2: c = 'h0A;
                    default: c = 'h0D;
                endcase
            end
            5: c = CP_BITS'($urandom_range('h21, 'h40));
            6: c = CP_BITS'(cp_edges[$urandom_range(0, 43)] + $urandom_range(0, 2) - 1);
            default: c = CP_BITS'($urandom_range(0, 'h1FFFFF));
        endcase
        return c;
    endfunction

    task automatic load_texts(input int n_items);
        int   cnt;
        int   len;
        int   cat;
        int   r;
        logic kctx;
        logic blank;
        cnt = 0;
        cat = 0;
        while (cnt < n_items) begin
            r = $urandom_range(0, 9);
            len = (r < 6) ? $urandom_range(1, 8) : (r < 9) ? $urandom_range(9, 30)
                                                           : $urandom_range(31, 80);
            blank = ($urandom_range(0, 19) == 0);
            kctx  = $urandom_range(0, 1);
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(0, 99) >= 60) begin
                    r = $urandom_range(0, 99);
                    cat = (r < 15) ? 0 : (r < 28) ? 1 : (r < 43) ? 2 : (r < 61) ? 3 :
                          (r < 71) ? 4 : (r < 81) ? 5 : (r < 91) ? 6 : 7;
                end
                add_cp(blank ? pick_cp(4) : pick_cp(cat),
                       ($urandom_range(0, 9) == 0) ? !kctx : kctx, j == len - 1);
            end
            cnt += len;
        end
    endtask

    task automatic load_directed();
        add_cp('h41, 1'b0, 1'b1);
        add_cp('h3042, 1'b1, 1'b0);
        add_cp('h4E00, 1'b1, 1'b0);
        add_cp('h3001, 1'b1, 1'b0);
        add_cp('hAC00, 1'b1, 1'b0);
        add_cp('hFF21, 1'b1, 1'b0);
        add_cp('h7A, 1'b1, 1'b1);
        add_cp('h20, 1'b0, 1'b0);
        add_cp('h09, 1'b0, 1'b0);
        add_cp('h0A, 1'b0, 1'b0);
        add_cp('h0D, 1'b0, 1'b1);
        add_cp('h30, 1'b0, 1'b0);
        add_cp('h7F, 1'b0, 1'b0);
        add_cp('h80, 1'b0, 1'b0);
        add_cp('h7FF, 1'b0, 1'b0);
        add_cp('h800, 1'b0, 1'b0);
        add_cp('hD800, 1'b0, 1'b0);
        add_cp('hFFFF, 1'b0, 1'b0);
        add_cp('h10000, 1'b0, 1'b0);
        add_cp('h10FFFF, 1'b0, 1'b0);
        add_cp('h1FFFFF, 1'b0, 1'b1);
        add_cp('h9FFF, 1'b0, 1'b0);
        add_cp('h21, 1'b0, 1'b0);
        add_cp('hFFDC, 1'b0, 1'b1);
    endtask

    initial begin
        en_ja    = 1'b0;
        en_zh    = 1'b0;
        en_ko    = 1'b0;
        en_latin = 1'b0;
        clear_text_state();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 9; ph++) begin
            case (ph / 3)
                0: begin
                    send_idle = 9;
                    recv_idle = 57;
                end
                1: begin
                    send_idle = 57;
                    recv_idle = 9;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            program_langs(lang_sets[ph]);
            if (ph == 0) begin
                load_directed();
            end
            load_texts(190);
            drain();
        end
        if (errs == 0 && segs_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
